// File: rtl/dqpi_pkg.sv
// Shared types and constants for the d/q current PI controller.
`default_nettype none

package dqpi_pkg;

    // register indexes (byte address / 8)
    localparam logic [2:0] REG_GAINS_LOW  = 3'd0;
    localparam logic [2:0] REG_GAINS_HIGH = 3'd1;
    localparam logic [2:0] REG_SPEED_LOW  = 3'd2;
    localparam logic [2:0] REG_SPEED_HIGH = 3'd3;
    localparam logic [2:0] REG_SCHED_EN   = 3'd4;
    localparam logic [2:0] REG_CLOCKWISE  = 3'd5;

    // phases of the two-chunk multiply
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_SUM    = 2'd2;

    typedef struct packed {
        logic [63:0] gains_low;
        logic [63:0] gains_high;
        logic [30:0] speed_low;
        logic [30:0] speed_high;
        logic        schedule_enable;
        logic        clockwise;
    } cfg_t;

    typedef enum logic [1:0] {
        MOP_GAIN,
        MOP_PROP,
        MOP_INTEG
    } mop_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       mul_en;
        mop_t       mul_op;
        logic [1:0] mul_phase;
        logic [1:0] idx;
        logic       clamp_i;
        logic       vout;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic blend;
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GAIN,
        S_PROP,
        S_INTEG,
        S_CLAMP,
        S_VOUT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/dqpi_regs.sv
// APB configuration registers.
`default_nettype none

module dqpi_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output dqpi_pkg::cfg_t    cfg
);

    dqpi_pkg::cfg_t cfg_reg;
    dqpi_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[5:3])
                dqpi_pkg::REG_GAINS_LOW:  cfg_next.gains_low       = pwdata;
                dqpi_pkg::REG_GAINS_HIGH: cfg_next.gains_high      = pwdata;
                dqpi_pkg::REG_SPEED_LOW:  cfg_next.speed_low       = pwdata[30:0];
                dqpi_pkg::REG_SPEED_HIGH: cfg_next.speed_high      = pwdata[30:0];
                dqpi_pkg::REG_SCHED_EN:   cfg_next.schedule_enable = pwdata[0];
                dqpi_pkg::REG_CLOCKWISE:  cfg_next.clockwise       = pwdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            dqpi_pkg::REG_GAINS_LOW:  prdata = cfg_reg.gains_low;
            dqpi_pkg::REG_GAINS_HIGH: prdata = cfg_reg.gains_high;
            dqpi_pkg::REG_SPEED_LOW:  prdata = 64'(cfg_reg.speed_low);
            dqpi_pkg::REG_SPEED_HIGH: prdata = 64'(cfg_reg.speed_high);
            dqpi_pkg::REG_SCHED_EN:   prdata = 64'(cfg_reg.schedule_enable);
            dqpi_pkg::REG_CLOCKWISE:  prdata = 64'(cfg_reg.clockwise);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// File: rtl/dqpi_ctrl.sv
// Sequencer for divide, gain blend and the two PI axes.
`default_nettype none

module dqpi_ctrl #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire dqpi_pkg::status_t status,
    output dqpi_pkg::cmd_t     cmd
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    dqpi_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.mul_op = dqpi_pkg::MOP_GAIN;
        cmd.mul_phase = phase_reg;
        cmd.idx    = idx_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            dqpi_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = dqpi_pkg::S_DIV;
                end
            end
            dqpi_pkg::S_DIV:
            begin
                phase_next = dqpi_pkg::PH_FIRST;
                idx_next   = '0;
                if (!status.blend)
                    state_next = dqpi_pkg::S_PROP;
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(FRAC_BITS - 1))
                        state_next = dqpi_pkg::S_GAIN;
                end
            end
            dqpi_pkg::S_GAIN, dqpi_pkg::S_PROP, dqpi_pkg::S_INTEG:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = (state_reg == dqpi_pkg::S_GAIN) ? dqpi_pkg::MOP_GAIN :
                             (state_reg == dqpi_pkg::S_PROP) ? dqpi_pkg::MOP_PROP :
                                                               dqpi_pkg::MOP_INTEG;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == dqpi_pkg::PH_SUM)
                begin
                    phase_next = dqpi_pkg::PH_FIRST;
                    if (state_reg == dqpi_pkg::S_GAIN)
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                        begin
                            idx_next   = '0;
                            state_next = dqpi_pkg::S_PROP;
                        end
                    end
                    else if (state_reg == dqpi_pkg::S_PROP)
                        state_next = dqpi_pkg::S_INTEG;
                    else
                        state_next = dqpi_pkg::S_CLAMP;
                end
            end
            dqpi_pkg::S_CLAMP:
            begin
                cmd.clamp_i = 1'b1;
                state_next  = dqpi_pkg::S_VOUT;
            end
            dqpi_pkg::S_VOUT:
            begin
                cmd.vout = 1'b1;
                if (idx_reg[0])
                    state_next = dqpi_pkg::S_DONE;
                else
                begin
                    idx_next   = 2'd1;
                    state_next = dqpi_pkg::S_PROP;
                end
            end
            dqpi_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = dqpi_pkg::S_IDLE;
                end
            end
            default: state_next = dqpi_pkg::S_IDLE;
        endcase

        out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqpi_pkg::S_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= dqpi_pkg::PH_FIRST;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dqpi_datapath.sv
// Divider, shared multiplier, integrators and clamps.
`default_nettype none

module dqpi_datapath #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dqpi_pkg::cfg_t      cfg,
    input  wire dqpi_pkg::cmd_t      cmd,
    output dqpi_pkg::status_t        status,
    input  wire logic signed [31:0]  id_command,
    input  wire logic signed [31:0]  iq_command,
    input  wire logic signed [31:0]  id_feedback,
    input  wire logic signed [31:0]  iq_feedback,
    input  wire logic [30:0]         vdc_limit,
    input  wire logic [30:0]         speed_abs,
    output logic signed [31:0]       vd_out,
    output logic signed [31:0]       vq_out,
    output logic signed [31:0]       iq_reference
);

    localparam int KW   = FRAC_BITS + 4;
    localparam int CH   = (KW + 1) / 2;
    localparam int BW   = 2 * CH;
    localparam int AW   = 34;
    localparam int PW   = AW + CH + 1;
    localparam int ACCW = AW + BW;
    localparam int UPW  = ACCW - FRAC_BITS;
    localparam int SW   = UPW + 2;
    localparam int GS   = FRAC_BITS - 12;

    logic signed [31:0]   idc_reg, idf_reg, iqf_reg;
    logic signed [32:0]   iqr_reg;
    logic [30:0]          vdc_reg;
    logic                 blend_reg;
    logic [30:0]          rem_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [KW-1:0]        k_reg [4];
    logic signed [PW-1:0] prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [UPW-1:0]  up_reg;
    logic signed [UPW:0]    isum_reg;
    logic signed [31:0]   integ_reg [2];
    logic signed [31:0]   v_reg [2];
    logic signed [31:0]   vd_reg, vq_reg, iqref_reg;

    logic signed [31:0]   d1, d2;
    logic                 sel_band, sel_blend, sel_high;
    logic [63:0]          src;
    logic signed [33:0]   err_d, err_q, err_sel;
    logic [31:0]          rem2;
    logic signed [16:0]   dg;
    logic [15:0]          lo_g;
    logic signed [AW-1:0] a_mux;
    logic [BW-1:0]        b_mux;
    logic [CH-1:0]        chunk;
    logic signed [ACCW-1:0] res, res_f, gsum;
    logic signed [SW-1:0] vdc_w, up_w, is_w, tmax, tmin, lim, ui, vs, vc;
    logic                 ax;

    assign vd_out       = vd_reg;
    assign vq_out       = vq_reg;
    assign iq_reference = iqref_reg;
    assign status.blend = blend_reg;
    assign ax           = cmd.idx[0];

    always_comb
    begin
        d1        = $signed({1'b0, speed_abs}) - $signed({1'b0, cfg.speed_low});
        d2        = $signed({1'b0, cfg.speed_high}) - $signed({1'b0, cfg.speed_low});
        sel_band  = cfg.schedule_enable && (d2 > 0) && (d1 > 0);
        sel_high  = sel_band && (d1 >= d2);
        sel_blend = sel_band && (d1 < d2);
        src       = sel_high ? cfg.gains_high : cfg.gains_low;

        // negated minimum q command against minimum feedback reaches 2^32
        err_d   = 34'(idc_reg) - 34'(idf_reg);
        err_q   = 34'(iqr_reg) - 34'(iqf_reg);
        err_sel = ax ? err_q : err_d;

        rem2 = {rem_reg, 1'b0};

        lo_g = cfg.gains_low[16*cmd.idx +: 16];
        dg   = $signed({1'b0, cfg.gains_high[16*cmd.idx +: 16]}) - $signed({1'b0, lo_g});

        case (cmd.mul_op)
            dqpi_pkg::MOP_GAIN:
            begin
                a_mux = AW'(dg);
                b_mux = BW'(quo_reg);
            end
            dqpi_pkg::MOP_PROP:
            begin
                a_mux = AW'(err_sel);
                b_mux = BW'(k_reg[{ax, 1'b0}]);
            end
            default:
            begin
                a_mux = AW'(err_sel);
                b_mux = BW'(k_reg[{ax, 1'b1}]);
            end
        endcase
        chunk = (cmd.mul_phase == dqpi_pkg::PH_FIRST) ? b_mux[CH-1:0] : b_mux[BW-1:CH];

        res   = acc_reg + (ACCW'(prod_reg) <<< CH);
        res_f = res >>> FRAC_BITS;
        gsum  = (res >>> 12) + $signed(ACCW'({lo_g, {GS{1'b0}}}));

        // anti-windup bounds shrink by the proportional term on the error's side
        vdc_w = $signed(SW'(vdc_reg));
        up_w  = SW'(up_reg);
        is_w  = SW'(isum_reg);
        lim   = err_sel > 0 ? vdc_w - up_w : -vdc_w - up_w;
        if (err_sel > 0)
        begin
            tmax = lim < 0 ? '0 : lim;
            tmin = -vdc_w;
        end
        else
        begin
            tmax = vdc_w;
            tmin = lim > 0 ? '0 : lim;
        end
        ui = is_w > tmax ? tmax : (is_w < tmin ? tmin : is_w);

        vs = up_w + SW'(integ_reg[ax]);
        vc = vs > vdc_w ? vdc_w : (vs < -vdc_w ? -vdc_w : vs);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idc_reg   <= id_command;
            idf_reg   <= id_feedback;
            iqf_reg   <= iq_feedback;
            iqr_reg   <= cfg.clockwise ? -33'(iq_command) : 33'(iq_command);
            vdc_reg   <= vdc_limit;
            blend_reg <= sel_blend;
            rem_reg   <= d1[30:0];
            quo_reg   <= '0;
            for (int i = 0; i < 4; i++)
                k_reg[i] <= {src[16*i +: 16], {GS{1'b0}}};
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            if (rem2 >= 32'(d2))
            begin
                rem_reg <= 31'(rem2 - 32'(d2));
                quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[30:0];
                quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= a_mux * $signed({1'b0, chunk});
            if (cmd.mul_phase == dqpi_pkg::PH_SECOND)
                acc_reg <= ACCW'(prod_reg);
            if (cmd.mul_phase == dqpi_pkg::PH_SUM)
            begin
                case (cmd.mul_op)
                    dqpi_pkg::MOP_GAIN: k_reg[cmd.idx] <= gsum[KW-1:0];
                    dqpi_pkg::MOP_PROP: up_reg <= res_f[UPW-1:0];
                    default:            isum_reg <= (UPW+1)'(integ_reg[ax]) + res_f[UPW:0];
                endcase
            end
        end
        if (cmd.vout)
            v_reg[ax] <= vc[31:0];
        if (cmd.out_load)
        begin
            vd_reg    <= v_reg[0];
            vq_reg    <= v_reg[1];
            iqref_reg <= (iqr_reg[32:31] == 2'b01) ? 32'sh7FFFFFFF : iqr_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
        end
        else if (cmd.clamp_i)
            integ_reg[ax] <= ui[31:0];
    end

endmodule

`default_nettype wire

// File: rtl/dq_current_pi_with_gain_schedule_top.sv
// Top level of the d/q current PI controller with gain scheduling.
// When the speed lies inside the scheduling band, a restoring divider first gives one
// blend-factor bit per cycle and four gain blends follow; outside the band both are skipped.
// Each multiply runs as two chunks through one shared multiplier, in a first-chunk, second-chunk
// and sum phase, and each axis runs its proportional and integral products, the integrator
// clamp and the output clamp in turn. The next request can be taken from the cycle in which the
// result appears, and a new request is taken while a finished result waits; a second result
// then stalls until the first is taken.
`default_nettype none

module dq_current_pi_with_gain_schedule_top #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] id_command,
    input  wire logic signed [31:0] iq_command,
    input  wire logic signed [31:0] id_feedback,
    input  wire logic signed [31:0] iq_feedback,
    input  wire logic [30:0]        vdc_limit,
    input  wire logic [30:0]        speed_abs,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      vd_out,
    output logic signed [31:0]      vq_out,
    output logic signed [31:0]      iq_reference
);

    dqpi_pkg::cfg_t    cfg;
    dqpi_pkg::cmd_t    cmd;
    dqpi_pkg::status_t status;

    dqpi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dqpi_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dqpi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .id_command   (id_command),
        .iq_command   (iq_command),
        .id_feedback  (id_feedback),
        .iq_feedback  (iq_feedback),
        .vdc_limit    (vdc_limit),
        .speed_abs    (speed_abs),
        .vd_out       (vd_out),
        .vq_out       (vq_out),
        .iq_reference (iq_reference)
    );

endmodule

`default_nettype wire

// File: rtl/dqpi_checker.sv
// Port-level checks for the d/q current PI controller, bound to the top level.
`default_nettype none

module dqpi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        pready,
    input wire logic [31:0] vd_out,
    input wire logic [31:0] vq_out,
    input wire logic [31:0] iq_reference
);

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready held after request accepted");

    // a result never appears the cycle after a request
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(vd_out) && $stable(vq_out)
                                       && $stable(iq_reference)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind dq_current_pi_with_gain_schedule_top dqpi_checker u_dqpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pready       (pready),
    .vd_out       (vd_out),
    .vq_out       (vq_out),
    .iq_reference (iq_reference)
);

`default_nettype wire
